@@ rtl/core/fcpp_pkg.sv @@
`default_nettype none

package fcpp_pkg;

    // Request kinds
    localparam logic ACT_BYTE = 1'b0;
    localparam logic ACT_TICK = 1'b1;

    // Special characters
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;
    localparam logic [7:0] CHAR_SPACE = 8'h20;

    // Slot map of one packet
    localparam logic [4:0] SLOT_ID_LAST  = 5'd3;
    localparam logic [4:0] SLOT_CMD_FIRST = 5'd4;
    localparam logic [4:0] SLOT_CMD_LAST = 5'd8;
    localparam logic [4:0] SLOT_P1_FIRST = 5'd9;
    localparam logic [4:0] SLOT_P1_LAST  = 5'd15;
    localparam logic [4:0] SLOT_P2_FIRST = 5'd16;
    localparam logic [4:0] SLOT_P2_LAST  = 5'd22;
    localparam logic [4:0] SLOT_TERM_CR  = 5'd23;
    localparam logic [4:0] SLOT_TERM_LF  = 5'd24;
    localparam logic [4:0] SLOT_OVER     = 5'd25;

    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    typedef enum logic [2:0] {
        ST_BUSY     = 3'd0,
        ST_DONE     = 3'd1,
        ST_TERM_ERR = 3'd2,
        ST_OVERFLOW = 3'd3,
        ST_TIMEOUT  = 3'd4
    } t_status;

    typedef struct packed {
        logic       action;
        logic [7:0] byte_value;
    } t_cmd_req;

    typedef struct packed {
        t_status     status;
        logic [31:0] id_field;
        logic [39:0] command_field;
        logic [55:0] first_param_field;
        logic [55:0] second_param_field;
        logic        packet_available;
        logic        terminator_error;
        logic        overflow_error;
    } t_cmd_rsp;

endpackage

`default_nettype wire

@@ rtl/core/fixed_field_command_packet_parser.sv @@
// Output: each result is registered in r_out, or in r_skid while r_out is stalled.
// Throughput: one request per cycle while o_stall is low; each byte or tick is a single
// slot compare and register update. A one-entry skid stage takes one more request while
// the output is stalled, so o_stall comes from a register and rises no sooner than i_stall.
// Reset: synchronous active-low; clears slot position, receive stores, latched
// fields, flags and idle count, and sets the timeout register to 1000 ticks.
`default_nettype none

module fixed_field_command_packet_parser (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_valid,
    output logic                    o_stall,
    input  wire fcpp_pkg::t_cmd_req i_data,
    output logic                    o_valid,
    input  wire logic               i_stall,
    output fcpp_pkg::t_cmd_rsp      o_data,
    input  wire logic               i_cfg_we,
    input  wire logic [15:0]        i_cfg_wdata
);
    import fcpp_pkg::*;

    logic        r_out_valid;
    logic        r_skid_valid;
    t_cmd_rsp    r_out;
    t_cmd_rsp    r_skid;
    logic [15:0] r_timeout;
    logic        w_in_accept;
    logic        w_out_take;
    t_cmd_rsp    w_rsp;

    assign w_in_accept = i_valid && !r_skid_valid;
    assign w_out_take  = r_out_valid && !i_stall;
    assign o_stall     = r_skid_valid;
    assign o_valid     = r_out_valid;
    assign o_data      = r_out;

    fcpp_parser u_parser (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_accept        (w_in_accept),
        .i_req           (i_data),
        .i_timeout_ticks (r_timeout),
        .o_rsp           (w_rsp)
    );

    // Hold the timeout setting and the output/skid occupancy
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_timeout    <= TIMEOUT_RESET;
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_timeout <= i_cfg_wdata;
            end
            if (!r_out_valid || w_out_take) begin
                r_out_valid  <= r_skid_valid || w_in_accept;
                r_skid_valid <= 1'b0;
            end else if (w_in_accept) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    // Advance result payloads
    always_ff @(posedge i_clk) begin
        if (!r_out_valid || w_out_take) begin
            r_out <= r_skid_valid ? r_skid : w_rsp;
        end
        if (r_out_valid && i_stall && w_in_accept) begin
            r_skid <= w_rsp;
        end
    end

`ifndef SYNTHESIS
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held with empty output register");

    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> r_out_valid)
        else $error("stalled result dropped");

    a_skid_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !i_stall) |=> (r_out_valid && !r_skid_valid))
        else $error("skid entry not moved to output");
`endif

endmodule

`default_nettype wire

@@ rtl/core/fcpp_parser.sv @@
`default_nettype none

module fcpp_parser (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_accept,
    input  wire fcpp_pkg::t_cmd_req i_req,
    input  wire logic [15:0]       i_timeout_ticks,
    output fcpp_pkg::t_cmd_rsp     o_rsp
);
    import fcpp_pkg::*;

    logic [4:0]  r_slot,     n_slot;
    logic [31:0] r_id,       n_id;
    logic [39:0] r_cmd,      n_cmd;
    logic [55:0] r_p1,       n_p1;
    logic [55:0] r_p2,       n_p2;
    logic [15:0] r_term,     n_term;
    logic [15:0] r_idle,     n_idle;
    logic [31:0] r_lat_id,   n_lat_id;
    logic [39:0] r_lat_cmd,  n_lat_cmd;
    logic [55:0] r_lat_p1,   n_lat_p1;
    logic [55:0] r_lat_p2,   n_lat_p2;
    logic        r_avail,    n_avail;
    logic        r_term_err, n_term_err;
    logic        r_ovf,      n_ovf;

    t_status     w_status;
    logic [4:0]  w_pos;
    logic        w_advance;
    logic        w_space;
    logic [7:0]  w_store;
    logic [2:0]  w_cmd_idx;
    logic [2:0]  w_p1_idx;
    logic [2:0]  w_p2_idx;
    logic [4:0]  w_cmd_off;
    logic [4:0]  w_p1_off;
    logic [4:0]  w_p2_off;

    // Byte offsets inside each field
    assign w_cmd_off = r_slot - SLOT_CMD_FIRST;
    assign w_p1_off  = r_slot - SLOT_P1_FIRST;
    assign w_p2_off  = r_slot - SLOT_P2_FIRST;
    assign w_cmd_idx = w_cmd_off[2:0];
    assign w_p1_idx  = w_p1_off[2:0];
    assign w_p2_idx  = w_p2_off[2:0];
    assign w_space   = (i_req.byte_value == CHAR_SPACE);
    assign w_store   = w_space ? 8'h00 : i_req.byte_value;

    // Compute next parser state for one request
    always_comb begin
        n_slot     = r_slot;
        n_id       = r_id;
        n_cmd      = r_cmd;
        n_p1       = r_p1;
        n_p2       = r_p2;
        n_term     = r_term;
        n_idle     = r_idle;
        n_lat_id   = r_lat_id;
        n_lat_cmd  = r_lat_cmd;
        n_lat_p1   = r_lat_p1;
        n_lat_p2   = r_lat_p2;
        n_avail    = r_avail;
        n_term_err = r_term_err;
        n_ovf      = r_ovf;
        w_status   = ST_BUSY;
        w_pos      = r_slot;
        w_advance  = 1'b0;

        if (i_accept) begin
            if (i_req.action == ACT_TICK) begin
                // Count idle time, drop the packet on timeout
                n_idle = (r_idle == 16'hFFFF) ? r_idle : r_idle + 16'd1;
                if (n_idle >= i_timeout_ticks) begin
                    n_slot   = '0;
                    n_id     = '0;
                    n_cmd    = '0;
                    n_p1     = '0;
                    n_p2     = '0;
                    n_term   = '0;
                    n_idle   = '0;
                    w_status = ST_TIMEOUT;
                end
            end else begin
                n_idle    = '0;
                w_advance = 1'b1;
                if (r_slot <= SLOT_ID_LAST) begin
                    n_id[{r_slot[1:0], 3'b000} +: 8] = w_store;
                    if (w_space) begin
                        w_pos = SLOT_ID_LAST;
                    end
                end else if (r_slot <= SLOT_CMD_LAST) begin
                    n_cmd[{w_cmd_idx, 3'b000} +: 8] = w_store;
                    if (w_space) begin
                        w_pos = SLOT_CMD_LAST;
                    end
                end else if (r_slot <= SLOT_P1_LAST) begin
                    if (i_req.byte_value == CHAR_CR) begin
                        // Early end: both parameters start empty
                        n_term[7:0] = CHAR_CR;
                        n_p1[7:0]   = 8'h00;
                        n_p2[7:0]   = 8'h00;
                        w_pos       = SLOT_TERM_CR;
                    end else begin
                        n_p1[{w_p1_idx, 3'b000} +: 8] = w_store;
                        if (w_space) begin
                            w_pos = SLOT_P1_LAST;
                        end
                    end
                end else if (r_slot <= SLOT_P2_LAST) begin
                    if (i_req.byte_value == CHAR_CR) begin
                        n_term[7:0] = CHAR_CR;
                        n_p2[7:0]   = 8'h00;
                        w_pos       = SLOT_TERM_CR;
                    end else begin
                        n_p2[{w_p2_idx, 3'b000} +: 8] = w_store;
                        if (w_space) begin
                            w_pos = SLOT_P2_LAST;
                        end
                    end
                end else if (r_slot == SLOT_TERM_CR) begin
                    n_term[7:0] = i_req.byte_value;
                end else if (r_slot == SLOT_TERM_LF) begin
                    n_term[15:8] = i_req.byte_value;
                    if (r_term[7:0] == CHAR_CR && i_req.byte_value == CHAR_LF) begin
                        // Good packet: latch fields and restart
                        n_lat_id  = r_id;
                        n_lat_cmd = r_cmd;
                        n_lat_p1  = r_p1;
                        n_lat_p2  = r_p2;
                        n_avail   = 1'b1;
                        n_slot    = '0;
                        n_id      = '0;
                        n_cmd     = '0;
                        n_p1      = '0;
                        n_p2      = '0;
                        n_term    = '0;
                        w_advance = 1'b0;
                        w_status  = ST_DONE;
                    end else begin
                        n_term_err = 1'b1;
                        w_status   = ST_TERM_ERR;
                    end
                end else begin
                    // Past the terminator: hold at the overflow slot
                    n_ovf     = 1'b1;
                    n_avail   = 1'b0;
                    n_slot    = SLOT_OVER;
                    w_advance = 1'b0;
                    w_status  = ST_OVERFLOW;
                end
                if (w_advance) begin
                    n_slot = w_pos + 5'd1;
                end
            end
        end
    end

    // Result as seen after this request
    always_comb begin
        o_rsp.status             = w_status;
        o_rsp.id_field           = n_lat_id;
        o_rsp.command_field      = n_lat_cmd;
        o_rsp.first_param_field  = n_lat_p1;
        o_rsp.second_param_field = n_lat_p2;
        o_rsp.packet_available   = n_avail;
        o_rsp.terminator_error   = n_term_err;
        o_rsp.overflow_error     = n_ovf;
    end

    // Parser state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_id       <= '0;
            r_cmd      <= '0;
            r_p1       <= '0;
            r_p2       <= '0;
            r_term     <= '0;
            r_idle     <= '0;
            r_lat_id   <= '0;
            r_lat_cmd  <= '0;
            r_lat_p1   <= '0;
            r_lat_p2   <= '0;
            r_avail    <= 1'b0;
            r_term_err <= 1'b0;
            r_ovf      <= 1'b0;
        end else begin
            r_slot     <= n_slot;
            r_id       <= n_id;
            r_cmd      <= n_cmd;
            r_p1       <= n_p1;
            r_p2       <= n_p2;
            r_term     <= n_term;
            r_idle     <= n_idle;
            r_lat_id   <= n_lat_id;
            r_lat_cmd  <= n_lat_cmd;
            r_lat_p1   <= n_lat_p1;
            r_lat_p2   <= n_lat_p2;
            r_avail    <= n_avail;
            r_term_err <= n_term_err;
            r_ovf      <= n_ovf;
        end
    end

`ifndef SYNTHESIS
    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_OVER)
        else $error("slot position out of range");

    a_ovf_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |=> r_ovf)
        else $error("overflow flag dropped");

    a_term_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_term_err |=> r_term_err)
        else $error("terminator error flag dropped");

    a_ovf_kills_avail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_accept && i_req.action == ACT_BYTE && r_slot == SLOT_OVER)
            |=> (!r_avail && r_ovf && r_slot == SLOT_OVER))
        else $error("byte past terminator not flagged as overflow");
`endif

endmodule

`default_nettype wire

@@ verif/tb.sv @@
`timescale 1ns / 100ps

module tb;
    import fcpp_pkg::*;

    localparam int LONG_HOLD   = 400;
    localparam int DRAIN_LIMIT = 20000;

    // Tracks the parser state and queues the full response each request must produce
    class parse_scoreboard;
        t_cmd_rsp expected_q[$];
        int       mismatches;

        logic [15:0] timeout_ticks;
        logic [4:0]  pos;
        logic [31:0] asm_id;
        logic [39:0] asm_cmd;
        logic [55:0] asm_p1;
        logic [55:0] asm_p2;
        logic [15:0] asm_crlf;
        logic [15:0] idle_ticks;
        logic [31:0] shown_id;
        logic [39:0] shown_cmd;
        logic [55:0] shown_p1;
        logic [55:0] shown_p2;
        logic        avail;
        logic        term_err;
        logic        ovf_err;

        function new();
            timeout_ticks = TIMEOUT_RESET;
            restart_packet();
            shown_id  = '0;
            shown_cmd = '0;
            shown_p1  = '0;
            shown_p2  = '0;
            avail     = 1'b0;
            term_err  = 1'b0;
            ovf_err   = 1'b0;
        endfunction

        function void restart_packet();
            pos        = '0;
            asm_id     = '0;
            asm_cmd    = '0;
            asm_p1     = '0;
            asm_p2     = '0;
            asm_crlf   = '0;
            idle_ticks = '0;
        endfunction

        function void set_timeout(logic [15:0] value);
            timeout_ticks = value;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function logic [4:0] slot_now();
            return pos;
        endfunction

        // Place one received byte into its slot
        function t_status take_byte(logic [7:0] b);
            logic [4:0] p;
            t_status    st;
            p = pos;
            st = ST_BUSY;
            idle_ticks = '0;
            if (p <= SLOT_ID_LAST) begin
                if (b == CHAR_SPACE) begin
                    asm_id[8*p +: 8] = 8'h00;
                    p = SLOT_ID_LAST;
                end else begin
                    asm_id[8*p +: 8] = b;
                end
            end else if (p <= SLOT_CMD_LAST) begin
                if (b == CHAR_SPACE) begin
                    asm_cmd[8*(p - SLOT_CMD_FIRST) +: 8] = 8'h00;
                    p = SLOT_CMD_LAST;
                end else begin
                    asm_cmd[8*(p - SLOT_CMD_FIRST) +: 8] = b;
                end
            end else if (p <= SLOT_P1_LAST) begin
                if (b == CHAR_CR) begin
                    asm_crlf[7:0] = b;
                    asm_p1[7:0]   = 8'h00;
                    asm_p2[7:0]   = 8'h00;
                    p = SLOT_TERM_CR;
                end else if (b == CHAR_SPACE) begin
                    asm_p1[8*(p - SLOT_P1_FIRST) +: 8] = 8'h00;
                    p = SLOT_P1_LAST;
                end else begin
                    asm_p1[8*(p - SLOT_P1_FIRST) +: 8] = b;
                end
            end else if (p <= SLOT_P2_LAST) begin
                if (b == CHAR_CR) begin
                    asm_crlf[7:0] = b;
                    asm_p2[7:0]   = 8'h00;
                    p = SLOT_TERM_CR;
                end else if (b == CHAR_SPACE) begin
                    asm_p2[8*(p - SLOT_P2_FIRST) +: 8] = 8'h00;
                    p = SLOT_P2_LAST;
                end else begin
                    asm_p2[8*(p - SLOT_P2_FIRST) +: 8] = b;
                end
            end else if (p <= SLOT_TERM_LF) begin
                asm_crlf[8*(p - SLOT_TERM_CR) +: 8] = b;
                if (p == SLOT_TERM_LF) begin
                    if (asm_crlf[7:0] == CHAR_CR && asm_crlf[15:8] == CHAR_LF) begin
                        shown_id  = asm_id;
                        shown_cmd = asm_cmd;
                        shown_p1  = asm_p1;
                        shown_p2  = asm_p2;
                        avail     = 1'b1;
                        restart_packet();
                        return ST_DONE;
                    end
                    term_err = 1'b1;
                    st = ST_TERM_ERR;
                end
            end else begin
                ovf_err = 1'b1;
                avail   = 1'b0;
                pos     = SLOT_OVER;
                return ST_OVERFLOW;
            end
            p = p + 5'd1;
            pos = (p > SLOT_OVER) ? SLOT_OVER : p;
            return st;
        endfunction

        // Count one idle tick, restart on timeout
        function t_status take_tick();
            if (idle_ticks != 16'hFFFF)
                idle_ticks = idle_ticks + 16'd1;
            if (idle_ticks >= timeout_ticks) begin
                restart_packet();
                return ST_TIMEOUT;
            end
            return ST_BUSY;
        endfunction

        function void note_request(t_cmd_req req);
            t_cmd_rsp r;
            if (req.action == ACT_BYTE)
                r.status = take_byte(req.byte_value);
            else
                r.status = take_tick();
            r.id_field           = shown_id;
            r.command_field      = shown_cmd;
            r.first_param_field  = shown_p1;
            r.second_param_field = shown_p2;
            r.packet_available   = avail;
            r.terminator_error   = term_err;
            r.overflow_error     = ovf_err;
            expected_q.push_back(r);
        endfunction

        function void check_result(t_cmd_rsp got);
            t_cmd_rsp want;
            if (expected_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with no request pending: %p", $realtime, got);
                return;
            end
            want = expected_q.pop_front();
            if (got.status !== want.status || got.id_field !== want.id_field ||
                got.command_field !== want.command_field ||
                got.first_param_field !== want.first_param_field ||
                got.second_param_field !== want.second_param_field ||
                got.packet_available !== want.packet_available ||
                got.terminator_error !== want.terminator_error ||
                got.overflow_error !== want.overflow_error) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: mismatch status exp %0d got %0d id exp %h got %h",
                             $realtime, want.status, got.status, want.id_field,
                             got.id_field);
                    $display("  cmd exp %h got %h p1 exp %h got %h p2 exp %h got %h",
                             want.command_field, got.command_field,
                             want.first_param_field, got.first_param_field,
                             want.second_param_field, got.second_param_field);
                    $display("  flags avail/term/ovf exp %b%b%b got %b%b%b",
                             want.packet_available, want.terminator_error,
                             want.overflow_error, got.packet_available,
                             got.terminator_error, got.overflow_error);
                end
            end
        endfunction
    endclass

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic        o_stall;
    t_cmd_req    i_data      = '0;
    logic        o_valid;
    logic        i_stall     = 1'b0;
    t_cmd_rsp    o_data;
    logic        i_cfg_we    = 1'b0;
    logic [15:0] i_cfg_wdata = '0;

    parse_scoreboard sb = new();

    t_cmd_req pkt_q[$];
    int       sent_items    = 0;
    bit       quiet         = 1'b0;
    bit       hold_request  = 1'b0;
    int       rx_stall_left = 0;
    int       rx_gap;

    logic [7:0] warmup_bytes [23] = '{
        8'h41, CHAR_SPACE, 8'h42, CHAR_SPACE, 8'hFF, CHAR_SPACE, 8'h00, CHAR_CR, CHAR_LF,
        8'h58, CHAR_SPACE, 8'h59, CHAR_SPACE, 8'h5A, CHAR_CR, CHAR_LF,
        CHAR_SPACE, CHAR_SPACE, CHAR_SPACE, CHAR_SPACE, 8'h51, 8'h52, 8'h80
    };

    fixed_field_command_packet_parser uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Mostly no gap, some short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 70)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        if (r < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [7:0] rand_byte();
        return 8'($urandom_range(0, 255));
    endfunction

    // Random character that carries no special meaning
    function automatic logic [7:0] rand_char();
        logic [7:0] b;
        b = rand_byte();
        if (b == CHAR_SPACE || b == CHAR_CR)
            b = b + 8'h40;
        return b;
    endfunction

    function automatic t_cmd_req make_req(logic act, logic [7:0] b);
        t_cmd_req r;
        r.action     = act;
        r.byte_value = b;
        return r;
    endfunction

    // Check results and drive the output stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall)
            sb.check_result(o_data);
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (rx_stall_left > 0) begin
            rx_stall_left = rx_stall_left - 1;
            i_stall <= 1'b1;
        end else if (hold_request) begin
            hold_request  = 1'b0;
            rx_stall_left = LONG_HOLD - 1;
            i_stall <= 1'b1;
        end else begin
            rx_gap = pick_gap();
            if (rx_gap > 0) begin
                rx_stall_left = rx_gap - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
        end
    end

    // Offer one request, hold it until accepted, then maybe idle
    task automatic send_item(t_cmd_req req);
        int gap;
        i_valid <= 1'b1;
        i_data  <= req;
        do @(posedge i_clk); while (o_stall);
        sb.note_request(req);
        sent_items++;
        gap = pick_gap();
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic send_tick();
        send_item(make_req(ACT_TICK, rand_byte()));
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_timeout(logic [15:0] value);
        wait_drained();
        repeat (2) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_timeout(value);
    endtask

    // Queue a byte, now and then preceded by an idle tick
    task automatic add_byte(logic [7:0] b);
        if ($urandom_range(0, 23) == 0)
            pkt_q.push_back(make_req(ACT_TICK, rand_byte()));
        pkt_q.push_back(make_req(ACT_BYTE, b));
    endtask

    // Fill a field fully, or cut it short with a space (or CR in a parameter)
    task automatic add_field(int width, bit is_param, output bit cr_end);
        int n;
        n = ($urandom_range(0, 2) == 0) ? $urandom_range(0, width - 1) : width;
        cr_end = 1'b0;
        for (int k = 0; k < n; k++)
            add_byte(rand_char());
        if (n < width) begin
            if (is_param && $urandom_range(0, 3) == 0) begin
                add_byte(CHAR_CR);
                cr_end = 1'b1;
            end else begin
                add_byte(CHAR_SPACE);
            end
        end
    endtask

    // Build one packet; noisy traffic sometimes breaks it or sends raw bytes
    task automatic build_packet(bit noisy);
        bit cr_end;
        int kind;
        pkt_q.delete();
        kind = (noisy && $urandom_range(0, 5) == 0) ? $urandom_range(1, 3) : 0;
        if (kind == 3) begin
            repeat ($urandom_range(1, 40)) add_byte(rand_byte());
            return;
        end
        add_field(4, 1'b0, cr_end);
        add_field(5, 1'b0, cr_end);
        add_field(7, 1'b1, cr_end);
        if (!cr_end) begin
            add_field(7, 1'b1, cr_end);
            if (!cr_end)
                add_byte((kind == 1 && $urandom_range(0, 1) == 0) ? rand_byte() : CHAR_CR);
        end
        add_byte((kind == 1) ? rand_byte() : CHAR_LF);
        if (kind != 0)
            repeat ($urandom_range(0, 4)) add_byte(rand_byte());
    endtask

    // Tick until the parser is back at the first slot
    task automatic resync();
        while (sb.slot_now() != '0) send_tick();
    endtask

    task automatic run_traffic(bit noisy, int budget);
        int start;
        int span;
        start = sent_items;
        resync();
        while (sent_items - start < budget) begin
            build_packet(noisy);
            foreach (pkt_q[k]) send_item(pkt_q[k]);
            resync();
            if (noisy && $urandom_range(0, 7) == 0) begin
                span = sb.timeout_ticks + 2;
                repeat ($urandom_range(0, span)) send_tick();
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: spaces in every field, CR in each parameter, good and bad ends
        write_timeout(TIMEOUT_RESET);
        foreach (warmup_bytes[k]) send_item(make_req(ACT_BYTE, warmup_bytes[k]));
        send_item(make_req(ACT_TICK, 8'hFF));
        send_item(make_req(ACT_TICK, 8'h00));

        write_timeout(16'd1);
        run_traffic(1'b1, 250);

        // Long receiver hold while requests keep coming
        write_timeout(16'd5);
        run_traffic(1'b1, 150);
        hold_request = 1'b1;
        run_traffic(1'b1, 150);

        // Pause the sender until all results are back
        write_timeout(16'd24);
        run_traffic(1'b1, 150);
        wait_drained();
        run_traffic(1'b1, 150);

        quiet = 1'b1;
        write_timeout(16'd60);
        run_traffic(1'b1, 300);
        quiet = 1'b0;

        write_timeout(TIMEOUT_RESET);
        run_traffic(1'b0, 200);

        // Largest timeout: break a packet, then idle a while without expiring it
        write_timeout(16'hFFFF);
        run_traffic(1'b0, 150);
        quiet = 1'b1;
        send_item(make_req(ACT_BYTE, rand_char()));
        send_item(make_req(ACT_BYTE, rand_char()));
        send_item(make_req(ACT_BYTE, rand_char()));
        repeat (40) send_tick();
        quiet = 1'b0;

        write_timeout(16'd13);
        run_traffic(1'b1, 300);

        begin
            int waited;
            waited = 0;
            i_valid <= 1'b0;
            while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
                @(posedge i_clk);
                waited++;
            end
            repeat (4) @(posedge i_clk);
            if (sb.pending() == 0 && sb.mismatches == 0)
                $display("SUCCESS");
            else
                $display("FAILURE");
            $finish;
        end
    end

    // Hard stop in case the handshake hangs
    initial begin
        #48000000;
        $display("FAILURE");
        $finish;
    end

endmodule
